[hw/rtl/bgab_pkg.sv]
// ----------------------------------------------------------------------------
// bgab_pkg: shared types, constants and helpers
// Fixed-point widths for the bilinear coverage path, register indexes and
// the divide-by-255 used by the alpha and channel blend.
// ----------------------------------------------------------------------------
package bgab_pkg;

  localparam int unsigned FRACTION_BITS = 8;          // valid range 4..16
  localparam int unsigned FracOneW      = FRACTION_BITS + 1;
  localparam int unsigned LerpW         = 8 + FRACTION_BITS;      // horizontal lerp
  localparam int unsigned VertW         = 8 + 2 * FRACTION_BITS;  // vertical lerp

  localparam logic [FracOneW-1:0] FracOne = FracOneW'(1) << FRACTION_BITS;

  // register indexes
  localparam logic [1:0] RegColorRed   = 2'd0;
  localparam logic [1:0] RegColorGreen = 2'd1;
  localparam logic [1:0] RegColorBlue  = 2'd2;
  localparam logic [1:0] RegColorAlpha = 2'd3;

  typedef logic [FRACTION_BITS-1:0] frac_t;
  typedef logic [LerpW-1:0]         lerp_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // low FRACTION_BITS of an 8-bit fraction field, zero-extended if wider
  function automatic frac_t frac_sel(input logic [7:0] f);
    logic [FRACTION_BITS+7:0] ext;
    ext = {{FRACTION_BITS{1'b0}}, f};
    return ext[FRACTION_BITS-1:0];
  endfunction

  // floor(x / 255), exact for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'd1 + 17'(x[15:8]);
    return s[15:8];
  endfunction

endpackage

[hw/rtl/bgab_cov.sv]
// ----------------------------------------------------------------------------
// bgab_cov: bilinear coverage pipeline
// Stage 1 does both horizontal lerps, stage 2 the vertical lerp and the
// truncation to 8-bit coverage. Destination pixel rides along.
// ----------------------------------------------------------------------------
module bgab_cov (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      tl_i,
  input  logic [7:0]      tr_i,
  input  logic [7:0]      bl_i,
  input  logic [7:0]      br_i,
  input  logic [7:0]      fu_i,
  input  logic [7:0]      fv_i,
  input  bgab_pkg::rgb_t  dest_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [7:0]      cov_o,
  output bgab_pkg::rgb_t  dest_o
);

  logic v1_q, v2_q;
  logic en1, en2;

  bgab_pkg::lerp_t top_d, bot_d, top_q, bot_q;
  bgab_pkg::frac_t fu, fv_q;
  bgab_pkg::rgb_t  dest1_q, dest2_q;
  logic [bgab_pkg::FracOneW-1:0] fu_inv, fv_inv;
  logic [bgab_pkg::VertW-1:0]    vert;
  logic [7:0] cov_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  assign fu     = bgab_pkg::frac_sel(fu_i);
  assign fu_inv = bgab_pkg::FracOne - bgab_pkg::FracOneW'(fu);
  assign top_d  = bgab_pkg::LerpW'(tl_i) * bgab_pkg::LerpW'(fu_inv)
                + bgab_pkg::LerpW'(tr_i) * bgab_pkg::LerpW'(fu);
  assign bot_d  = bgab_pkg::LerpW'(bl_i) * bgab_pkg::LerpW'(fu_inv)
                + bgab_pkg::LerpW'(br_i) * bgab_pkg::LerpW'(fu);

  assign fv_inv = bgab_pkg::FracOne - bgab_pkg::FracOneW'(fv_q);
  assign vert   = bgab_pkg::VertW'(top_q) * bgab_pkg::VertW'(fv_inv)
                + bgab_pkg::VertW'(bot_q) * bgab_pkg::VertW'(fv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      top_q   <= top_d;
      bot_q   <= bot_d;
      fv_q    <= bgab_pkg::frac_sel(fv_i);
      dest1_q <= dest_i;
    end
    if (en2) begin
      cov_q   <= vert[2*bgab_pkg::FRACTION_BITS +: 8];
      dest2_q <= dest1_q;
    end
  end

  assign valid_o = v2_q;
  assign cov_o   = cov_q;
  assign dest_o  = dest2_q;

endmodule

[hw/rtl/bgab_blend.sv]
// ----------------------------------------------------------------------------
// bgab_blend: alpha scale and per-channel blend pipeline
// Stage 1 scales coverage by color alpha, stage 2 divides by 255 and forms
// the weighted channel sums, stage 3 divides those by 255 (output register).
// ----------------------------------------------------------------------------
module bgab_blend (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      cov_i,
  input  bgab_pkg::rgb_t  dest_i,
  input  bgab_pkg::rgb_t  color_i,
  input  logic [7:0]      alpha_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bgab_pkg::rgb_t  pix_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic [15:0]    prod_q;
  bgab_pkg::rgb_t dest1_q, pix_q;
  logic [7:0]     a, a_inv;
  logic [15:0]    sum_r_d, sum_g_d, sum_b_d;
  logic [15:0]    sum_r_q, sum_g_q, sum_b_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  assign a       = bgab_pkg::div255(prod_q);
  assign a_inv   = 8'd255 - a;
  assign sum_r_d = 16'(dest1_q.red)   * 16'(a_inv) + 16'(color_i.red)   * 16'(a);
  assign sum_g_d = 16'(dest1_q.green) * 16'(a_inv) + 16'(color_i.green) * 16'(a);
  assign sum_b_d = 16'(dest1_q.blue)  * 16'(a_inv) + 16'(color_i.blue)  * 16'(a);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q  <= 16'(cov_i) * 16'(alpha_i);
      dest1_q <= dest_i;
    end
    if (en2) begin
      sum_r_q <= sum_r_d;
      sum_g_q <= sum_g_d;
      sum_b_q <= sum_b_d;
    end
    if (en3) begin
      pix_q.red   <= bgab_pkg::div255(sum_r_q);
      pix_q.green <= bgab_pkg::div255(sum_g_q);
      pix_q.blue  <= bgab_pkg::div255(sum_b_q);
    end
  end

  assign valid_o = v3_q;
  assign pix_o   = pix_q;

endmodule

[hw/rtl/bilinear_glyph_alpha_blend.sv]
// ----------------------------------------------------------------------------
// bilinear_glyph_alpha_blend: per-pixel glyph text blender
// Bilinear coverage from four glyph texels, scaled by text alpha, blended
// into the destination RGB pixel toward the configured text color.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Width  Contents
// s_axis    in   72     texels, fractions, destination pixel
// m_axis    out  24     blended pixel
// cfg       in   2+8    text color and alpha registers
//
// One word per clock sustained while m_axis is ready; each word passes
// 2 coverage stages and 3 blend stages, the last being the output register.
// Reset clears all valid bits and loads color 0,0,0 with alpha 255.
// A stall on m_axis holds the output register; bubbles upstream still
// collapse, so s_axis keeps accepting until every stage is full.
// Config writes apply to words at the alpha/blend stages, so write only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module bilinear_glyph_alpha_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] texel_top_left, [15:8] texel_top_right, [23:16] texel_bottom_left,
  // [31:24] texel_bottom_right, [39:32] frac_u, [47:40] frac_v,
  // [55:48] dest_red, [63:56] dest_green, [71:64] dest_blue
  input  logic [71:0] s_axis_tdata_i,
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic [23:0] m_axis_tdata_o,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // text color registers
  bgab_pkg::rgb_t color_q;
  logic [7:0]     alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
      alpha_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bgab_pkg::RegColorRed:   color_q.red   <= cfg_data_i;
        bgab_pkg::RegColorGreen: color_q.green <= cfg_data_i;
        bgab_pkg::RegColorBlue:  color_q.blue  <= cfg_data_i;
        bgab_pkg::RegColorAlpha: alpha_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input unpack
  bgab_pkg::rgb_t dest_in;
  assign dest_in.red   = s_axis_tdata_i[55:48];
  assign dest_in.green = s_axis_tdata_i[63:56];
  assign dest_in.blue  = s_axis_tdata_i[71:64];

  // coverage -> blend link
  logic           cov_valid, cov_ready;
  logic [7:0]     cov;
  bgab_pkg::rgb_t cov_dest;
  bgab_pkg::rgb_t pix;

  bgab_cov u_cov (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .tl_i    (s_axis_tdata_i[7:0]),
    .tr_i    (s_axis_tdata_i[15:8]),
    .bl_i    (s_axis_tdata_i[23:16]),
    .br_i    (s_axis_tdata_i[31:24]),
    .fu_i    (s_axis_tdata_i[39:32]),
    .fv_i    (s_axis_tdata_i[47:40]),
    .dest_i  (dest_in),
    .valid_o (cov_valid),
    .ready_i (cov_ready),
    .cov_o   (cov),
    .dest_o  (cov_dest)
  );

  bgab_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cov_valid),
    .ready_o (cov_ready),
    .cov_i   (cov),
    .dest_i  (cov_dest),
    .color_i (color_q),
    .alpha_i (alpha_q),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .pix_o   (pix)
  );

  // output pack
  assign m_axis_tdata_o = {pix.blue, pix.green, pix.red};

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: bilinear_glyph_alpha_blend
// Drives texel/fraction/destination words into the blender, predicts each
// blended pixel from its own fixed-point model of the coverage and blend
// math, and checks every output word in order. Covers register extremes,
// random color settings, random idle bursts on both sides, a long output
// stall and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PIPE_LATENCY   = 5;
  localparam int STALL_LIMIT    = 2000;  // cycles with no word moving on either side
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 100;

  typedef struct {
    logic [7:0] tex_tl;
    logic [7:0] tex_tr;
    logic [7:0] tex_bl;
    logic [7:0] tex_br;
    logic [7:0] frac_u;
    logic [7:0] frac_v;
    logic [7:0] dest_red;
    logic [7:0] dest_green;
    logic [7:0] dest_blue;
  } pixel_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } blended_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = bgab_pkg::RegColorRed;
  logic [7:0]  cfg_data = '0;

  // text color as the block should hold it
  logic [7:0] text_red   = 8'd0;
  logic [7:0] text_green = 8'd0;
  logic [7:0] text_blue  = 8'd0;
  logic [7:0] text_alpha = 8'd255;

  blended_t pending_pixels[$];
  int       mismatch_count = 0;
  bit       bursts_on = 1'b1;   // random idle bursts on both sides
  int       hold_request = 0;   // long output stall asked by a test

  bilinear_glyph_alpha_blend u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    // [7:0] tl, [15:8] tr, [23:16] bl, [31:24] br, [39:32] frac_u,
    // [47:40] frac_v, [55:48] dest_red, [63:56] dest_green, [71:64] dest_blue
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [7:0] mix_channel(input logic [7:0] dest, input logic [7:0] col,
                                             input longint unsigned a);
    longint unsigned acc;
    acc = (longint'(dest) * (255 - a) + longint'(col) * a) / 255;
    return acc[7:0];
  endfunction

  function automatic blended_t blend_pixel(input pixel_t p);
    longint unsigned one, fu, fv, top, bot, cov, a;
    blended_t r;
    one = 64'd1 << bgab_pkg::FRACTION_BITS;
    // a fraction never reaches ONE: only its low FRACTION_BITS bits count
    fu  = longint'(p.frac_u) & (one - 1);
    fv  = longint'(p.frac_v) & (one - 1);
    top = longint'(p.tex_tl) * (one - fu) + longint'(p.tex_tr) * fu;
    bot = longint'(p.tex_bl) * (one - fu) + longint'(p.tex_br) * fu;
    cov = ((top * (one - fv) + bot * fv) >> (2 * bgab_pkg::FRACTION_BITS)) & 64'hFF;
    a   = (cov * longint'(text_alpha)) / 255;
    r.red   = mix_channel(p.dest_red,   text_red,   a);
    r.green = mix_channel(p.dest_green, text_green, a);
    r.blue  = mix_channel(p.dest_blue,  text_blue,  a);
    return r;
  endfunction

  function automatic pixel_t make_pixel(input logic [7:0] tl, tr, bl, br, fu, fv,
                                        input logic [7:0] dr, dg, db);
    pixel_t p;
    p.tex_tl = tl;  p.tex_tr = tr;  p.tex_bl = bl;  p.tex_br = br;
    p.frac_u = fu;  p.frac_v = fv;
    p.dest_red = dr;  p.dest_green = dg;  p.dest_blue = db;
    return p;
  endfunction

  // mostly uniform, with extra weight on the two extremes
  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_t rand_pixel();
    return make_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                      rand_byte(), rand_byte(), rand_byte(), rand_byte());
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks. All of them are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // offer one word until accepted; valid stays up for a back-to-back word
  task automatic send_pixel(input pixel_t p);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.dest_blue, p.dest_green, p.dest_red, p.frac_v, p.frac_u,
                      p.tex_br, p.tex_bl, p.tex_tr, p.tex_tl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_pixels.push_back(blend_pixel(p));
    @(negedge clk_i);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
  endtask

  // stop offering, let every expected pixel come out, then let the pipe settle
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // single register write; caller has drained the pipe
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      bgab_pkg::RegColorRed:   text_red   = val;
      bgab_pkg::RegColorGreen: text_green = val;
      bgab_pkg::RegColorBlue:  text_blue  = val;
      bgab_pkg::RegColorAlpha: text_alpha = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_text_color(input logic [7:0] r, g, b, a);
    drain_pipe();
    write_reg(bgab_pkg::RegColorRed,   r);
    write_reg(bgab_pkg::RegColorGreen, g);
    write_reg(bgab_pkg::RegColorBlue,  b);
    write_reg(bgab_pkg::RegColorAlpha, a);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset color is black at full alpha
  task automatic test_reset_color();
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd12, 8'd200, 8'd255));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd90, 8'd255, 8'd1));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
    // largest fractions: the far corner carries most of the weight
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd200, 8'd100, 8'd50));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd200, 8'd100, 8'd50));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(8'd128, 8'd64, 8'd32, 8'd16, 8'd128, 8'd128, 8'd77, 8'd177, 8'd7));
  endtask

  // color and alpha at their extremes
  task automatic test_color_extremes();
    set_text_color(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(8'd170, 8'd85, 8'd255, 8'd1, 8'd1, 8'd254, 8'd3, 8'd100, 8'd254));
    // alpha zero: destination passes through unchanged
    set_text_color(8'd255, 8'd0, 8'd255, 8'd0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd11, 8'd22, 8'd33));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd128));
    send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
    // mid alpha, mixed color
    set_text_color(8'd0, 8'd255, 8'd128, 8'd128);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd128, 8'd0, 8'd0, 8'd0));
    set_text_color(8'd1, 8'd254, 8'd127, 8'd1);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd254, 8'd1, 8'd128));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0));
    set_text_color(8'd200, 8'd30, 8'd90, 8'd254);
    send_pixel(make_pixel(8'd254, 8'd253, 8'd252, 8'd251, 8'd127, 8'd129, 8'd255, 8'd255, 8'd0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 8'd0, 8'd64, 8'd192, 8'd60, 8'd160, 8'd250));
  endtask

  // output held off long enough that the pipe fills and input stalls
  task automatic test_output_stall();
    set_text_color(8'd40, 8'd220, 8'd130, 8'd200);
    bursts_on    = 1'b0;
    hold_request = LONG_HOLD;
    repeat (40) send_pixel(rand_pixel());
    bursts_on    = 1'b1;
  endtask

  // random words under a series of color settings; last phase runs with no idling
  task automatic test_random_phases();
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: set_text_color(8'd0, 8'd0, 8'd0, 8'd0);
        1: set_text_color(8'd255, 8'd255, 8'd255, 8'd255);
        2: set_text_color(8'd0, 8'd255, 8'd0, 8'd255);
        default: set_text_color(rand_byte(), rand_byte(), rand_byte(), rand_byte());
      endcase
      if (ph == PHASE_COUNT - 1) bursts_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // a stretch without idling in the middle of one phase
        if (ph == 4) bursts_on = (n < 30 || n >= 60);
        // sender pauses until every pixel so far has come out
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_pipe();
        send_pixel(rand_pixel());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random ready bursts, plus the long hold when asked
  // --------------------------------------------------------------------------
  int hold_left  = 0;
  int burst_left = 0;

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!bursts_on) begin
      m_axis_tready <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      burst_left = $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
      burst_left = $urandom_range(0, 20);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each output word against the oldest expected pixel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    blended_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output word, actual %h", $realtime, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[7:0] !== want.red) begin
          $display("%0t: out_red expected %0d actual %0d",
                   $realtime, want.red, m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          $display("%0t: out_green expected %0d actual %0d",
                   $realtime, want.green, m_axis_tdata[15:8]);
          mismatch_count++;
        end
        if (m_axis_tdata[23:16] !== want.blue) begin
          $display("%0t: out_blue expected %0d actual %0d",
                   $realtime, want.blue, m_axis_tdata[23:16]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long without a word moving on either side
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d pixels still expected", $realtime, pending_pixels.size());
      $display("[bilinear_glyph_alpha_blend] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_color();
    test_color_extremes();
    test_output_stall();
    test_random_phases();

    drain_pipe();
    repeat (4 * PIPE_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("[bilinear_glyph_alpha_blend] OK");
    end else begin
      $display("[bilinear_glyph_alpha_blend] ERROR");
    end
    $finish;
  end

endmodule
